// ----- sv/osdtg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdtg_pkg: shared types and constants for the osd text glyph renderer
// Holds beat formats, register map, font geometry and the controller types.
// ----------------------------------------------------------------------------
package osdtg_pkg;

  // font geometry
  localparam int FIRST_CHAR      = 32;
  localparam int GLYPH_COUNT     = 96;
  localparam int BYTES_PER_GLYPH = 16;
  localparam int LINE_GAP        = 1;
  localparam int CHAR_GAP        = 1;
  localparam int DEFAULT_GLYPH   = 63;
  localparam int STORE_BYTES     = GLYPH_COUNT * BYTES_PER_GLYPH;
  localparam int STORE_AW        = $clog2(STORE_BYTES);
  localparam int GIDX_W          = ($clog2(GLYPH_COUNT) > 0) ? $clog2(GLYPH_COUNT) : 1;
  localparam int INK_ENTRIES     = 16;

  // signed width for screen geometry arithmetic
  localparam int GEO_W = 16;

  // apb register port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // character codes
  localparam logic [7:0] CHAR_NL     = 8'h0a;
  localparam logic [7:0] CHAR_BEL    = 8'h07;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] ESC_FREEZE  = 8'h30;
  localparam logic [7:0] ESC_THAW    = 8'h31;
  localparam logic [7:0] ESC_RESTORE = 8'h58;

  // item function codes
  typedef enum logic [1:0] {
    FN_START     = 2'd0,
    FN_CHAR      = 2'd1,
    FN_LOAD_FONT = 2'd2,
    FN_LOAD_INK  = 2'd3
  } func_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_CLIP_LEFT   = 3'd0,
    REG_CLIP_TOP    = 3'd1,
    REG_CLIP_SPAN_X = 3'd2,
    REG_CLIP_SPAN_Y = 3'd3,
    REG_BASE_WIDTH  = 3'd4,
    REG_GLYPH_ROWS  = 3'd5,
    REG_FIXED_PITCH = 3'd6
  } reg_e;

  // input beat
  typedef struct packed {
    logic [1:0]         func;
    logic signed [11:0] pen_start_x;
    logic signed [11:0] pen_start_y;
    logic [7:0]         item_byte;
    logic [11:0]        load_addr;
  } item_t;

  // output beat
  typedef struct packed {
    logic [11:0] row_line;
    logic [11:0] row_col;
    logic [7:0]  pixel_mask;
    logic [7:0]  ink;
    logic        last_row;
  } row_t;

  // configuration registers
  typedef struct packed {
    logic [11:0] clip_left;
    logic [11:0] clip_top;
    logic [12:0] clip_span_x;
    logic [12:0] clip_span_y;
    logic [3:0]  glyph_base_width;
    logic [3:0]  glyph_rows;
    logic        fixed_pitch;
  } cfg_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HDR,
    S_GEOM,
    S_PRIME,
    S_ROW
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic hdr;
    logic geom;
    logic prime;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic glyph;
    logic drawable;
    logic out_free;
    logic last;
    logic rows_left;
  } sts_t;

  // escape letter lookup result
  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } ink_hit_t;

  // escape letter to colour table entry
  function automatic ink_hit_t ink_lookup(input logic [7:0] code);
    ink_hit_t r;
    r.hit = 1'b1;
    r.idx = 4'd0;
    case (code)
      "k": r.idx = 4'd0;
      "b": r.idx = 4'd1;
      "r": r.idx = 4'd2;
      "m": r.idx = 4'd3;
      "g": r.idx = 4'd4;
      "c": r.idx = 4'd5;
      "y": r.idx = 4'd6;
      "w": r.idx = 4'd7;
      "K": r.idx = 4'd8;
      "B": r.idx = 4'd9;
      "R": r.idx = 4'd10;
      "M": r.idx = 4'd11;
      "G": r.idx = 4'd12;
      "C": r.idx = 4'd13;
      "Y": r.idx = 4'd14;
      "W": r.idx = 4'd15;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  // character code to glyph number, out of range codes use the default glyph
  function automatic logic [GIDX_W-1:0] glyph_index(input logic [7:0] code);
    logic [GIDX_W-1:0] idx;
    if (int'(code) >= FIRST_CHAR && int'(code) <= FIRST_CHAR + GLYPH_COUNT - 1) begin
      idx = GIDX_W'(int'(code) - FIRST_CHAR);
    end else begin
      idx = GIDX_W'(DEFAULT_GLYPH - FIRST_CHAR);
    end
    return idx;
  endfunction

endpackage

// ----- sv/osd_text_glyph_renderer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osd_text_glyph_renderer_top: on-screen text renderer
// Draws bitmap font glyphs as clipped eight-pixel row writes.
// ----------------------------------------------------------------------------
// start, load and control items pass through the execute state and return to idle
// a drawn character passes through header, geometry and prime, then n row writes (up to 15): one
// font store read per row, sequenced by the controller one item at a time
// the first row beat is registered after the execute, header, geometry and prime states
// synchronous reset restores register defaults, pen/ink state and idles
// the sequencer; font store and colour table contents are kept, not cleared
module osd_text_glyph_renderer_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  osdtg_pkg::item_t             item_data,
  output logic                         row_valid,
  input  logic                         row_stall,
  output osdtg_pkg::row_t              row_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [osdtg_pkg::APB_AW-1:0] paddr,
  input  logic [osdtg_pkg::APB_DW-1:0] pwdata,
  output logic [osdtg_pkg::APB_DW-1:0] prdata,
  output logic                         pready
);

  osdtg_pkg::cfg_t cfg;
  osdtg_pkg::cmd_t cmd;
  osdtg_pkg::sts_t st;

  // configuration registers
  osdtg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  osdtg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // datapath
  osdtg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item_data (item_data),
    .cmd       (cmd),
    .st        (st),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_data  (row_data)
  );

endmodule

// ----- sv/osdtg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdtg_regs: configuration register block
// APB-style write and readback of the clip window and font geometry.
// ----------------------------------------------------------------------------
module osdtg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [osdtg_pkg::APB_AW-1:0] paddr,
  input  logic [osdtg_pkg::APB_DW-1:0] pwdata,
  output logic [osdtg_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output osdtg_pkg::cfg_t             cfg
);

  logic       wr;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left        <= '0;
      cfg.clip_top         <= '0;
      cfg.clip_span_x      <= 13'd4096;
      cfg.clip_span_y      <= 13'd4096;
      cfg.glyph_base_width <= 4'd6;
      cfg.glyph_rows       <= 4'd9;
      cfg.fixed_pitch      <= 1'b0;
    end else if (wr) begin
      case (ridx)
        osdtg_pkg::REG_CLIP_LEFT:   cfg.clip_left        <= pwdata[11:0];
        osdtg_pkg::REG_CLIP_TOP:    cfg.clip_top         <= pwdata[11:0];
        osdtg_pkg::REG_CLIP_SPAN_X: cfg.clip_span_x      <= pwdata[12:0];
        osdtg_pkg::REG_CLIP_SPAN_Y: cfg.clip_span_y      <= pwdata[12:0];
        osdtg_pkg::REG_BASE_WIDTH:  cfg.glyph_base_width <= pwdata[3:0];
        osdtg_pkg::REG_GLYPH_ROWS:  cfg.glyph_rows       <= pwdata[3:0];
        osdtg_pkg::REG_FIXED_PITCH: cfg.fixed_pitch      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // readback
  always_comb begin
    prdata = '0;
    case (ridx)
      osdtg_pkg::REG_CLIP_LEFT:   prdata = osdtg_pkg::APB_DW'(cfg.clip_left);
      osdtg_pkg::REG_CLIP_TOP:    prdata = osdtg_pkg::APB_DW'(cfg.clip_top);
      osdtg_pkg::REG_CLIP_SPAN_X: prdata = osdtg_pkg::APB_DW'(cfg.clip_span_x);
      osdtg_pkg::REG_CLIP_SPAN_Y: prdata = osdtg_pkg::APB_DW'(cfg.clip_span_y);
      osdtg_pkg::REG_BASE_WIDTH:  prdata = osdtg_pkg::APB_DW'(cfg.glyph_base_width);
      osdtg_pkg::REG_GLYPH_ROWS:  prdata = osdtg_pkg::APB_DW'(cfg.glyph_rows);
      osdtg_pkg::REG_FIXED_PITCH: prdata = osdtg_pkg::APB_DW'(cfg.fixed_pitch);
      default:                    prdata = '0;
    endcase
  end

endmodule

// ----- sv/osdtg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdtg_ctrl: sequencing state machine
// Steps one item through execute and, for a glyph, header read, geometry, prime and row emission.
// ----------------------------------------------------------------------------
module osdtg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  osdtg_pkg::sts_t     st,
  output osdtg_pkg::cmd_t     cmd
);

  osdtg_pkg::state_e state;
  osdtg_pkg::state_e state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osdtg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      osdtg_pkg::S_IDLE:  if (item_valid) state_next = osdtg_pkg::S_EXEC;
      osdtg_pkg::S_EXEC:  state_next = st.glyph ? osdtg_pkg::S_HDR : osdtg_pkg::S_IDLE;
      osdtg_pkg::S_HDR:   state_next = osdtg_pkg::S_GEOM;
      osdtg_pkg::S_GEOM:  state_next = osdtg_pkg::S_PRIME;
      osdtg_pkg::S_PRIME: state_next = st.drawable ? osdtg_pkg::S_ROW : osdtg_pkg::S_IDLE;
      osdtg_pkg::S_ROW:   if (st.out_free && st.last) state_next = osdtg_pkg::S_IDLE;
      default:            state_next = osdtg_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall = (state != osdtg_pkg::S_IDLE);
    cmd        = '0;
    case (state)
      osdtg_pkg::S_IDLE:  cmd.latch = item_valid;
      osdtg_pkg::S_EXEC:  cmd.exec  = 1'b1;
      osdtg_pkg::S_HDR:   cmd.hdr   = 1'b1;
      osdtg_pkg::S_GEOM:  cmd.geom  = 1'b1;
      osdtg_pkg::S_PRIME: cmd.prime = 1'b1;
      osdtg_pkg::S_ROW:   cmd.emit  = st.out_free;
      default:            cmd       = '0;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted item is executed in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == osdtg_pkg::S_EXEC))
    else $error("accepted item not executed");

  // final row write returns to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (state == osdtg_pkg::S_ROW && st.out_free && st.last) |=> (state == osdtg_pkg::S_IDLE))
    else $error("no return to idle after final row");

  // row emission only with rows outstanding
  a_row_count: assert property (@(posedge clk) disable iff (rst)
    (state == osdtg_pkg::S_ROW) |-> st.rows_left)
    else $error("row state with no rows left");
`endif

endmodule

// ----- sv/osdtg_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osdtg_dpath: renderer datapath
// Pen and ink state, font store, colour table, glyph geometry, row register.
// ----------------------------------------------------------------------------
module osdtg_dpath (
  input  logic                 clk,
  input  logic                 rst,
  input  osdtg_pkg::cfg_t      cfg,
  input  osdtg_pkg::item_t     item_data,
  input  osdtg_pkg::cmd_t      cmd,
  output osdtg_pkg::sts_t      st,
  output logic                 row_valid,
  input  logic                 row_stall,
  output osdtg_pkg::row_t      row_data
);

  localparam int GW = osdtg_pkg::GEO_W;
  localparam int AW = osdtg_pkg::STORE_AW;

  // latched item and architectural state
  osdtg_pkg::item_t   item;
  logic signed [12:0] pen_x;
  logic signed [12:0] pen_y;
  logic signed [12:0] margin_x;
  logic [7:0]         current_ink;
  logic [7:0]         fallback_ink;
  logic               colours_enabled;
  logic               escape_pending;

  // stores
  logic [7:0] glyph_store [osdtg_pkg::STORE_BYTES];
  logic [7:0] colour_table [osdtg_pkg::INK_ENTRIES];
  logic [7:0] store_q;

  // glyph working registers
  logic [osdtg_pkg::GIDX_W-1:0] gidx;
  logic                         space_char;
  logic signed [GW-1:0]         gx;
  logic signed [5:0]            gw;
  logic signed [GW-1:0]         y_from;
  logic signed [GW-1:0]         y_to;
  logic                         draw;
  logic [3:0]                   roff;
  logic [3:0]                   cnt;
  logic [11:0]                  line;
  logic [11:0]                  col;

  // decode
  logic                         is_char;
  logic                         is_nl;
  logic                         is_bel;
  logic                         glyph_path;
  osdtg_pkg::ink_hit_t          esc_hit;
  logic [osdtg_pkg::GIDX_W-1:0] gidx_in;

  assign is_char    = (item.func == osdtg_pkg::FN_CHAR);
  assign is_nl      = (item.item_byte == osdtg_pkg::CHAR_NL);
  assign is_bel     = (item.item_byte == osdtg_pkg::CHAR_BEL);
  assign glyph_path = is_char && !is_nl && !is_bel && !escape_pending;
  assign esc_hit    = osdtg_pkg::ink_lookup(item.item_byte);
  assign gidx_in    = osdtg_pkg::glyph_index(item.item_byte);

  // item register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= item_data;
    end
  end

  // header decode
  logic [3:0]           hdr_shift;
  logic [3:0]           hdr_extra;
  logic signed [GW-1:0] pen_x_w;
  logic signed [GW-1:0] gx_next;
  logic signed [5:0]    gw_next;

  assign hdr_shift = store_q[7:4];
  assign hdr_extra = store_q[3:0];
  assign pen_x_w   = GW'(pen_x);
  assign gx_next   = cfg.fixed_pitch ? (pen_x_w + $signed(GW'(hdr_shift))) : pen_x_w;
  assign gw_next   = cfg.fixed_pitch
                     ? ($signed({2'b00, cfg.glyph_base_width}) - $signed({2'b00, hdr_shift}))
                     : ($signed({2'b00, cfg.glyph_base_width}) + $signed({2'b00, hdr_extra}));

  // geometry terms
  logic signed [GW-1:0] gw_w;
  logic signed [GW-1:0] x_end;
  logic signed [GW-1:0] clip_l;
  logic signed [GW-1:0] clip_r;
  logic signed [GW-1:0] clip_t;
  logic signed [GW-1:0] clip_b;
  logic signed [GW-1:0] pen_y_w;
  logic signed [GW-1:0] y_bot;
  logic signed [GW-1:0] top_gap;
  logic signed [GW-1:0] x_adv;
  logic signed [GW-1:0] n_rows;
  logic                 rows_ok;

  assign gw_w    = GW'(gw);
  assign x_end   = gx + gw_w;
  assign clip_l  = $signed(GW'(cfg.clip_left));
  assign clip_r  = $signed(GW'(cfg.clip_left)) + $signed(GW'(cfg.clip_span_x));
  assign clip_t  = $signed(GW'(cfg.clip_top));
  assign clip_b  = $signed(GW'(cfg.clip_top)) + $signed(GW'(cfg.clip_span_y));
  assign pen_y_w = GW'(pen_y);
  assign y_bot   = pen_y_w + $signed(GW'(cfg.glyph_rows));
  assign top_gap = clip_t - pen_y_w;
  assign x_adv   = x_end + $signed(GW'(osdtg_pkg::CHAR_GAP));
  assign n_rows  = y_to - y_from;
  assign rows_ok = draw && (n_rows > $signed(GW'(0)));

  // pen, ink and escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x           <= '0;
      pen_y           <= '0;
      margin_x        <= '0;
      current_ink     <= '0;
      fallback_ink    <= '0;
      colours_enabled <= 1'b1;
      escape_pending  <= 1'b0;
    end else if (cmd.exec) begin
      case (item.func)
        osdtg_pkg::FN_START: begin
          pen_x           <= 13'(item.pen_start_x);
          pen_y           <= 13'(item.pen_start_y);
          margin_x        <= 13'(item.pen_start_x);
          current_ink     <= item.item_byte;
          fallback_ink    <= item.item_byte;
          colours_enabled <= 1'b1;
          escape_pending  <= 1'b0;
        end
        osdtg_pkg::FN_CHAR: begin
          if (is_nl) begin
            pen_x <= margin_x;
            pen_y <= pen_y + $signed({9'd0, cfg.glyph_rows})
                     + $signed(13'(osdtg_pkg::LINE_GAP));
          end else if (is_bel) begin
            escape_pending <= 1'b1;
          end else if (escape_pending) begin
            escape_pending <= 1'b0;
            if (!colours_enabled) begin
              if (item.item_byte == osdtg_pkg::ESC_THAW) begin
                colours_enabled <= 1'b1;
              end
            end else if (esc_hit.hit) begin
              current_ink <= colour_table[esc_hit.idx];
            end else if (item.item_byte == osdtg_pkg::ESC_FREEZE) begin
              colours_enabled <= 1'b0;
              fallback_ink    <= current_ink;
            end else if (item.item_byte == osdtg_pkg::ESC_RESTORE) begin
              current_ink <= fallback_ink;
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.geom) begin
      pen_x <= x_adv[12:0];
    end
  end

  // colour table writes
  always_ff @(posedge clk) begin
    if (cmd.exec && item.func == osdtg_pkg::FN_LOAD_INK &&
        int'(item.load_addr) < osdtg_pkg::INK_ENTRIES) begin
      colour_table[item.load_addr[3:0]] <= item.item_byte;
    end
  end

  // font store port: header read, row reads and loads
  logic          st_wr;
  logic          st_rd;
  logic [4:0]    rd_off;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] glyph_base;

  assign st_wr = cmd.exec && item.func == osdtg_pkg::FN_LOAD_FONT &&
                 int'(item.load_addr) < osdtg_pkg::STORE_BYTES;
  assign st_rd = (cmd.exec && glyph_path) || (cmd.prime && rows_ok) ||
                 (cmd.emit && cnt != 4'd1);

  always_comb begin
    if (cmd.exec) begin
      glyph_base = AW'(gidx_in) * AW'(osdtg_pkg::BYTES_PER_GLYPH);
      rd_off     = 5'd0;
    end else begin
      glyph_base = AW'(gidx) * AW'(osdtg_pkg::BYTES_PER_GLYPH);
      rd_off     = cmd.prime ? ({1'b0, roff} + 5'd1) : ({1'b0, roff} + 5'd2);
    end
    rd_addr = glyph_base + AW'(rd_off);
  end

  always_ff @(posedge clk) begin
    if (st_wr) begin
      glyph_store[item.load_addr[AW-1:0]] <= item.item_byte;
    end
    if (st_rd) begin
      store_q <= glyph_store[rd_addr];
    end
  end

  // glyph working registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      gidx       <= gidx_in;
      space_char <= (item.item_byte == osdtg_pkg::CHAR_SPACE);
    end
    if (cmd.hdr) begin
      gx <= gx_next;
      gw <= gw_next;
    end
    if (cmd.geom) begin
      draw   <= !space_char && (gx >= clip_l) && (x_end <= clip_r);
      y_from <= (pen_y_w > clip_t) ? pen_y_w : clip_t;
      y_to   <= (clip_b < y_bot) ? clip_b : y_bot;
      roff   <= (clip_t > pen_y_w) ? top_gap[3:0] : 4'd0;
      col    <= gx[11:0];
    end
    if (cmd.prime) begin
      cnt  <= n_rows[3:0];
      line <= y_from[11:0];
    end
    if (cmd.emit) begin
      cnt  <= cnt - 4'd1;
      line <= line + 12'd1;
      roff <= roff + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (cmd.emit) begin
      row_valid <= 1'b1;
    end else if (!row_stall) begin
      row_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_data.row_line   <= line;
      row_data.row_col    <= col;
      row_data.pixel_mask <= store_q;
      row_data.ink        <= current_ink;
      row_data.last_row   <= (cnt == 4'd1);
    end
  end

  // status
  assign st.glyph     = glyph_path;
  assign st.drawable  = rows_ok;
  assign st.out_free  = !row_valid || !row_stall;
  assign st.last      = (cnt == 4'd1);
  assign st.rows_left = (cnt != 4'd0);

endmodule
